FILE: design/sparse_pattern_pair_insert_defines.svh
// Assertion macros for the sparse pattern pair insert block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPARSE_PATTERN_PAIR_INSERT_DEFINES_SVH
`define SPARSE_PATTERN_PAIR_INSERT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPPI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sppi_pkg.sv
// Package for the sparse pattern pair insert block: sizes, status codes, pool entry type.
// Depends on nothing.
package sppi_pkg;

    localparam int NUM_COLUMNS  = 1024;
    localparam int POOL_ENTRIES = 4096;

    localparam int IDX_W   = 11;
    localparam int COL_W   = $clog2(NUM_COLUMNS);
    localparam int ROW_W   = COL_W;
    localparam int POOL_AW = $clog2(POOL_ENTRIES);
    localparam int SLOT_W  = 13;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_PRESENT   = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] next;
    } pool_entry_t;

    localparam int POOL_W = ROW_W + SLOT_W;

endpackage

FILE: design/sppi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sppi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sparse_pattern_pair_insert.sv
// Sparse pattern pair insert: column head table and (row, next) pool in RAM, chain walk FSM.
// Depends on sppi_pkg, sppi_ram and sparse_pattern_pair_insert_defines.svh.
// Sequence: accept, head table read, one pool read per link visited, allocation, and a tail link
//   when appending behind a tail; a hit skips allocation, a bad index goes straight to the result.
// Throughput: one transaction at a time, next accepted in the cycle after the result register loads.
// Reset: clearing pass over the 1024-entry head table with s_ready low; no pool clear.
`include "sparse_pattern_pair_insert_defines.svh"

module sparse_pattern_pair_insert
    import sppi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IDX_W-1:0]  s_index_a,
    input  logic [IDX_W-1:0]  s_index_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [SLOT_W-1:0] m_entries_used
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] last_reg, last_next;
    logic [ROW_W-1:0]  last_row_reg, last_row_next;
    logic [SLOT_W-1:0] used_reg, used_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic [SLOT_W-1:0] m_entries_reg, m_entries_next;

    logic [IDX_W-1:0]  idx_lo, idx_hi;
    logic              idx_bad;

    logic              head_we;
    logic [COL_W-1:0]  head_waddr;
    logic [SLOT_W-1:0] head_wdata;
    logic [COL_W-1:0]  head_raddr;
    logic [SLOT_W-1:0] head_rdata;

    logic              pool_we;
    logic [POOL_AW-1:0] pool_waddr;
    pool_entry_t       pool_wdata;
    logic [POOL_AW-1:0] pool_raddr;
    logic [POOL_W-1:0] pool_rdata_raw;
    pool_entry_t       pool_rdata;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] new_slot;

    assign idx_lo  = (s_index_a < s_index_b) ? s_index_a : s_index_b;
    assign idx_hi  = (s_index_a < s_index_b) ? s_index_b : s_index_a;
    assign idx_bad = (idx_lo == '0) || (idx_hi > IDX_W'(NUM_COLUMNS));

    assign pool_rdata = pool_entry_t'(pool_rdata_raw);
    assign new_slot   = used_reg + SLOT_W'(1);
    assign rd_slot    = (state_reg == S_HEAD) ? head_rdata : pool_rdata.next;
    assign pool_raddr = POOL_AW'(rd_slot - SLOT_W'(1));
    assign head_raddr = COL_W'(idx_hi - IDX_W'(1));

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        last_row_next   = last_row_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_entries_next  = m_entries_reg;
        head_we         = 1'b0;
        head_waddr      = col_reg;
        head_wdata      = new_slot;
        pool_we         = 1'b0;
        pool_waddr      = POOL_AW'(used_reg);
        pool_wdata.row  = row_reg;
        pool_wdata.next = '0;

        unique case (state_reg)
            S_CLEAR: begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                head_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == COL_W'(NUM_COLUMNS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    col_next  = COL_W'(idx_hi - IDX_W'(1));
                    row_next  = ROW_W'(idx_lo - IDX_W'(1));
                    last_next = '0;
                    if (idx_bad) begin
                        res_status_next = ST_BAD_INDEX;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                cur_next = head_rdata;
                if (head_rdata == '0) begin
                    state_next = S_ALLOC;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (pool_rdata.row == row_reg) begin
                    res_status_next = ST_PRESENT;
                    res_slot_next   = cur_reg;
                    state_next      = S_DONE;
                end else begin
                    last_next     = cur_reg;
                    last_row_next = pool_rdata.row;
                    cur_next      = pool_rdata.next;
                    if (pool_rdata.next == '0) begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (used_reg >= SLOT_W'(POOL_ENTRIES)) begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    pool_we         = 1'b1;
                    used_next       = new_slot;
                    res_status_next = ST_INSERTED;
                    res_slot_next   = new_slot;
                    if (last_reg == '0) begin
                        head_we    = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK: begin
                pool_we         = 1'b1;
                pool_waddr      = POOL_AW'(last_reg - SLOT_W'(1));
                pool_wdata.row  = last_row_reg;
                pool_wdata.next = res_slot_reg;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_slot_next    = res_slot_reg;
                    m_entries_next = used_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        col_reg        <= col_next;
        row_reg        <= row_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        last_row_reg   <= last_row_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_entries_reg  <= m_entries_next;
    end

    sppi_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_COLUMNS)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    sppi_ram #(
        .WIDTH (POOL_W),
        .DEPTH (POOL_ENTRIES)
    ) u_pool_ram (
        .aclk  (aclk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (POOL_W'(pool_wdata)),
        .raddr (pool_raddr),
        .rdata (pool_rdata_raw)
    );

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot         = m_slot_reg;
    assign m_entries_used = m_entries_reg;

    // inserted slot is always the most recent allocation
    `SPPI_ASSERT_SAME(a_ins_slot, aclk, aresetn, m_valid_reg && (m_status_reg == ST_INSERTED), m_slot_reg == m_entries_reg, "inserted slot differs from entries used")
    // dropped transactions report slot zero, kept ones a real slot
    `SPPI_ASSERT_SAME(a_slot_zero, aclk, aresetn, m_valid_reg, (m_slot_reg == '0) == ((m_status_reg == ST_FULL) || (m_status_reg == ST_BAD_INDEX)), "slot zero mismatch with status")
    `SPPI_ASSERT_SAME(a_used_bound, aclk, aresetn, 1'b1, used_reg <= SLOT_W'(POOL_ENTRIES), "pool count beyond pool size")
    `SPPI_ASSERT_NEXT(a_used_step, aclk, aresetn, 1'b1, (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + SLOT_W'(1)), "pool count jumped")

endmodule
